[src/bda_pkg.sv]
// ----------------------------------------------------------------------------
// bda_pkg: shared constants and types for the BCD decimal accumulator
// Digit counts, item kind and relation codes, result word layout.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int MAXDIG = 30;           // digits carried by the ports
	localparam int DIGITS = 30;           // digits kept in the total (16..30)
	localparam int NIB    = 4;
	localparam int HALF_W = 60;
	localparam int WORD_W = 2 * HALF_W;

	localparam int IN_DATA_W  = WORD_W;
	localparam int OUT_DATA_W = 128;

	// result word layout
	localparam int OUT_REL_LSB   = 0;
	localparam int OUT_APPLIED   = 2;
	localparam int OUT_TLOW_LSB  = 3;
	localparam int OUT_THIGH_LSB = OUT_TLOW_LSB + HALF_W;
	localparam int OUT_OVERFLOW  = OUT_THIGH_LSB + HALF_W;
	localparam int OUT_BAD       = OUT_OVERFLOW + 1;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_CMP = 2'd2;

	localparam logic [1:0] REL_LESS    = 2'd0;
	localparam logic [1:0] REL_EQUAL   = 2'd1;
	localparam logic [1:0] REL_GREATER = 2'd2;

	localparam logic [NIB-1:0] DIGIT_MAX = 4'd9;
	localparam logic [NIB-1:0] DIGIT_ADJ = 4'd6;

	function automatic logic [WORD_W-1:0] digit_mask();
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAXDIG; i++) begin
			if (i < DIGITS) m[NIB*i +: NIB] = '1;
		end
		return m;
	endfunction

	localparam logic [WORD_W-1:0] DIGIT_MASK = digit_mask();

	typedef struct packed {
		logic [1:0]        relation;
		logic              applied;
		logic              overflow;
		logic              bad_digit;
		logic [WORD_W-1:0] total;
	} alu_res_t;

endpackage

[src/bcd_decimal_accumulator.sv]
// ----------------------------------------------------------------------------
// bcd_decimal_accumulator: 30-digit packed BCD running total
// Add, subtract-if-less and compare against the total, one result per request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: operand_low, operand_high; tuser: kind
//  m_*       out  m_tvalid/m_tready   tdata: relation, applied, total_low,
//                                     total_high, overflow, bad_digit
//
//  One request per cycle while results are taken; each request goes from the input
//  register to the result register, which offers its result. The total is read and
//  written in that move, so back-to-back requests chain directly. A stalled result
//  holds the result register and a full input register; reset clears the total to zero.
module bcd_decimal_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bda_pkg::IN_DATA_W-1:0]    s_tdata,   // operand_low, operand_high
	input  logic [1:0]                       s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bda_pkg::OUT_DATA_W-1:0]   m_tdata    // relation, applied, total_low,
	                                                    // total_high, overflow, bad_digit, pad
);

	logic                        valid_s1;
	logic [1:0]                  kind_s1;
	logic [bda_pkg::WORD_W-1:0]  operand_s1;
	logic                        valid_s2;
	bda_pkg::alu_res_t           res_s2;
	bda_pkg::alu_res_t           alu_res;
	logic [bda_pkg::WORD_W-1:0]  acc_q;
	logic                        adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	bda_alu u_alu (
		.kind    (kind_s1),
		.operand (operand_s1),
		.acc     (acc_q),
		.res     (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) begin
				valid_s2 <= 1'b1;
				acc_q    <= alu_res.total;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1    <= s_tuser;
			operand_s1 <= s_tdata;
		end
		if (adv) res_s2 <= alu_res;
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[bda_pkg::OUT_REL_LSB +: 2]              = res_s2.relation;
		m_tdata[bda_pkg::OUT_APPLIED]                   = res_s2.applied;
		m_tdata[bda_pkg::OUT_TLOW_LSB +: bda_pkg::WORD_W] = res_s2.total;
		m_tdata[bda_pkg::OUT_OVERFLOW]                  = res_s2.overflow;
		m_tdata[bda_pkg::OUT_BAD]                       = res_s2.bad_digit;
	end

	assign m_tvalid = valid_s2;

endmodule

[src/bda_alu.sv]
// ----------------------------------------------------------------------------
// bda_alu: decimal add / conditional subtract / compare datapath
// One shared binary adder with per-digit +6 bias and digit-local correction.
// ----------------------------------------------------------------------------
module bda_alu (
	input  logic [1:0]                kind,
	input  logic [bda_pkg::WORD_W-1:0] operand,
	input  logic [bda_pkg::WORD_W-1:0] acc,
	output bda_pkg::alu_res_t         res
);

	logic [bda_pkg::WORD_W-1:0] op_m;
	logic [bda_pkg::WORD_W-1:0] addend;
	logic [bda_pkg::WORD_W:0]   sum;
	logic [bda_pkg::WORD_W:0]   cvec;
	logic [bda_pkg::WORD_W-1:0] fixed;
	logic                       bad;
	logic                       is_add;
	logic                       take;
	logic [1:0]                 rel;

	always_comb begin
		op_m   = operand & bda_pkg::DIGIT_MASK;
		is_add = (kind == bda_pkg::KIND_ADD);

		bad = 1'b0;
		for (int i = 0; i < bda_pkg::MAXDIG; i++) begin
			if (op_m[bda_pkg::NIB*i +: bda_pkg::NIB] > bda_pkg::DIGIT_MAX) bad = 1'b1;
		end

		// packed BCD orders the same as the binary word
		if (op_m < acc)       rel = bda_pkg::REL_LESS;
		else if (op_m == acc) rel = bda_pkg::REL_EQUAL;
		else                  rel = bda_pkg::REL_GREATER;

		// add: bias every digit by 6 so binary nibble carries are decimal carries
		// sub: two's complement; a missing nibble carry is a decimal borrow
		for (int i = 0; i < bda_pkg::MAXDIG; i++) begin
			addend[bda_pkg::NIB*i +: bda_pkg::NIB] = is_add ?
				op_m[bda_pkg::NIB*i +: bda_pkg::NIB] + bda_pkg::DIGIT_ADJ :
				~op_m[bda_pkg::NIB*i +: bda_pkg::NIB];
		end

		sum  = {1'b0, acc} + {1'b0, addend} + {{bda_pkg::WORD_W{1'b0}}, ~is_add};
		cvec = sum ^ {1'b0, acc} ^ {1'b0, addend};

		// either way a digit without carry out gets 6 taken off
		for (int i = 0; i < bda_pkg::MAXDIG; i++) begin
			fixed[bda_pkg::NIB*i +: bda_pkg::NIB] = cvec[bda_pkg::NIB*(i+1)] ?
				sum[bda_pkg::NIB*i +: bda_pkg::NIB] :
				sum[bda_pkg::NIB*i +: bda_pkg::NIB] - bda_pkg::DIGIT_ADJ;
		end
		fixed = fixed & bda_pkg::DIGIT_MASK;

		take = !bad && (is_add || (kind == bda_pkg::KIND_SUB && rel == bda_pkg::REL_LESS));

		res.relation  = bad ? bda_pkg::REL_LESS : rel;
		res.applied   = take;
		res.overflow  = take && is_add && cvec[bda_pkg::NIB*bda_pkg::DIGITS];
		res.bad_digit = bad;
		res.total     = take ? fixed : acc;
	end

endmodule

[src/bda_checker.sv]
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for the BCD decimal accumulator
// Result stability under stall, consistency of the result flags and input back-up.
// ----------------------------------------------------------------------------
module bda_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bda_pkg::OUT_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a request with a bad digit never reports a change
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[bda_pkg::OUT_BAD] |->
			!m_tdata[bda_pkg::OUT_APPLIED] && !m_tdata[bda_pkg::OUT_OVERFLOW] &&
			m_tdata[bda_pkg::OUT_REL_LSB +: 2] == bda_pkg::REL_LESS)
		else $error("bad digit result with side effects");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[bda_pkg::OUT_OVERFLOW] |-> m_tdata[bda_pkg::OUT_APPLIED])
		else $error("overflow without applied");

	// one input register: a stalled result must back up into the input side
	a_backup: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready || m_tready)
		else $error("input accepted past a full pipeline");

endmodule

bind bcd_decimal_accumulator bda_checker u_bda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/bcd_decimal_accumulator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_decimal_accumulator_test: self-checking bench for the BCD accumulator
// Drives add, subtract-if-less and compare requests with random gaps and
// stalls on both streams. A scoreboard keeps its own decimal total and checks
// every result field in order.
// ----------------------------------------------------------------------------
import bda_pkg::*;

typedef struct packed {
	logic [1:0]        relation;
	logic              applied;
	logic [HALF_W-1:0] total_low;
	logic [HALF_W-1:0] total_high;
	logic              overflow;
	logic              bad_digit;
} bcd_result_t;

class bcd_total_scoreboard;
	logic [WORD_W-1:0] total;
	bcd_result_t       expected_results[$];
	int                errors;

	function new();
		total = '0;
		errors = 0;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	// Apply one accepted request to the running total and queue its result.
	function void note_request(logic [1:0] kind, logic [WORD_W-1:0] operand);
		int unsigned op_dig [MAXDIG];
		int unsigned sum_dig [MAXDIG];
		int unsigned v;
		int unsigned carry;
		bit          found;
		bcd_result_t r;
		for (int i = 0; i < MAXDIG; i++) begin
			op_dig[i]  = (i < DIGITS) ? operand[NIB*i +: NIB] : 0;
			sum_dig[i] = (i < DIGITS) ? total[NIB*i +: NIB] : 0;
		end
		r = '0;
		r.relation = REL_EQUAL;
		for (int i = 0; i < DIGITS; i++) begin
			if (op_dig[i] > DIGIT_MAX) r.bad_digit = 1'b1;
		end
		if (r.bad_digit) begin
			// bad operand: request ignored, total untouched
			r.relation = REL_LESS;
		end else begin
			found = 1'b0;
			for (int i = MAXDIG - 1; i >= 0; i--) begin
				if (!found && op_dig[i] != sum_dig[i]) begin
					r.relation = (op_dig[i] < sum_dig[i]) ? REL_LESS : REL_GREATER;
					found = 1'b1;
				end
			end
			if (kind == KIND_ADD) begin
				carry = 0;
				for (int i = 0; i < DIGITS; i++) begin
					v = sum_dig[i] + op_dig[i] + carry;
					carry = (v >= 10) ? 1 : 0;
					sum_dig[i] = carry ? v - 10 : v;
				end
				r.overflow = carry[0];
				r.applied = 1'b1;
			end else if (kind == KIND_SUB && r.relation == REL_LESS) begin
				carry = 0;	// borrow
				for (int i = 0; i < DIGITS; i++) begin
					v = op_dig[i] + carry;
					if (sum_dig[i] < v) begin
						sum_dig[i] = sum_dig[i] + 10 - v;
						carry = 1;
					end else begin
						sum_dig[i] = sum_dig[i] - v;
						carry = 0;
					end
				end
				r.applied = 1'b1;
			end
			total = '0;
			for (int i = 0; i < DIGITS; i++) total[NIB*i +: NIB] = 4'(sum_dig[i]);
		end
		r.total_low = total[HALF_W-1:0];
		r.total_high = total[WORD_W-1:HALF_W];
		expected_results.push_back(r);
	endfunction

	function void report(string field, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
	endfunction

	function void check_result(logic [OUT_DATA_W-1:0] word);
		bcd_result_t want;
		bcd_result_t got;
		got.relation   = word[OUT_REL_LSB +: 2];
		got.applied    = word[OUT_APPLIED];
		got.total_low  = word[OUT_TLOW_LSB +: HALF_W];
		got.total_high = word[OUT_THIGH_LSB +: HALF_W];
		got.overflow   = word[OUT_OVERFLOW];
		got.bad_digit  = word[OUT_BAD];
		if (expected_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none actual %h", $time, word);
			return;
		end
		want = expected_results.pop_front();
		if (got.relation !== want.relation)
			report("relation", HALF_W'(want.relation), HALF_W'(got.relation));
		if (got.applied !== want.applied)
			report("applied", HALF_W'(want.applied), HALF_W'(got.applied));
		if (got.total_low !== want.total_low)
			report("total_low", want.total_low, got.total_low);
		if (got.total_high !== want.total_high)
			report("total_high", want.total_high, got.total_high);
		if (got.overflow !== want.overflow)
			report("overflow", HALF_W'(want.overflow), HALF_W'(got.overflow));
		if (got.bad_digit !== want.bad_digit)
			report("bad_digit", HALF_W'(want.bad_digit), HALF_W'(got.bad_digit));
	endfunction
endclass

module bcd_decimal_accumulator_test;

	localparam int GAP_MAX         = 14;
	localparam int HOLD_CYCLES     = 200;
	localparam int STALL_LIMIT     = 3000;
	localparam int RANDOM_REQUESTS = 1435;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_AT         = 300;
	localparam int QUIET_AT        = 700;
	localparam logic [1:0] KIND_RSVD = 2'd3;
	localparam logic [WORD_W-1:0] NINES = {MAXDIG{4'h9}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // operand_low, operand_high
	logic [1:0]            s_tuser;   // kind
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // relation, applied, total_low, total_high,
	                                  // overflow, bad_digit, pad

	bcd_total_scoreboard totals;
	bit                  calm;
	bit                  hold_req;

	bcd_decimal_accumulator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	function automatic logic [WORD_W-1:0] bcd_operand(int ndig);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < ndig; i++) w[NIB*i +: NIB] = 4'($urandom_range(0, 9));
		return w;
	endfunction

	function automatic int sig_digits(logic [WORD_W-1:0] w);
		int n;
		n = 0;
		for (int i = 0; i < MAXDIG; i++) begin
			if (w[NIB*i +: NIB] != 4'd0) n = i + 1;
		end
		return n;
	endfunction

	task automatic send(logic [1:0] kind, logic [WORD_W-1:0] operand);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= operand;
		s_tuser <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		totals.note_request(kind, operand);
	endtask

	// drop the request line so the last item is not offered again
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (totals.pending() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) totals.check_result(m_tdata);
	end

	// result side: random back-pressure, plus one long hold on request
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int sel;
		int pos;
		logic [1:0] kind;
		logic [WORD_W-1:0] operand;
		totals = new();
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_CMP;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send(KIND_CMP, '0);
		send(KIND_SUB, '0);                 // equal: not taken
		send(KIND_ADD, NINES);
		send(KIND_ADD, 120'd1);             // wraps to zero with carry out
		send(KIND_ADD, NINES);
		send(KIND_SUB, NINES);
		send(KIND_SUB, 120'd1);             // borrow-free, taken
		send(KIND_CMP, NINES);
		send(KIND_SUB, NINES);              // greater: not taken
		send(KIND_SUB, '0);                 // taken though total is unchanged
		send(KIND_ADD, '0);
		send(KIND_RSVD, 120'h5);            // reserved kind acts as compare
		send(KIND_ADD, 120'hA);             // bad lowest digit
		send(KIND_SUB, {4'hF, 116'd0});     // bad top digit
		send(KIND_RSVD, '1);
		send(KIND_CMP, 120'd1);
		send(KIND_ADD, {4'h5, 116'd0});
		send(KIND_ADD, {4'h5, 116'd0});     // top digit 4 + 5, no carry out
		send(KIND_SUB, 120'h999);           // long borrow chain
		send(KIND_CMP, totals.total);
		wait_idle();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == HOLD_AT) hold_req = 1'b1;
			// sender keeps offering while the result side is held
			calm = (n >= HOLD_AT && n < HOLD_AT + 80) || (n >= 900 && n < 1000);
			if (n == QUIET_AT) wait_idle();
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				operand = WORD_W'({$urandom, $urandom, $urandom, $urandom});
				kind = 2'($urandom_range(0, 3));
			end else if (sel < 10) begin
				operand = bcd_operand($urandom_range(0, DIGITS));
				pos = $urandom_range(0, DIGITS - 1);
				operand[NIB*pos +: NIB] = 4'($urandom_range(10, 15));
				kind = 2'($urandom_range(0, 3));
			end else if (sel < 45) begin
				operand = bcd_operand($urandom_range(0, DIGITS));
				kind = KIND_ADD;
			end else if (sel < 80) begin
				kind = KIND_SUB;
				case ($urandom_range(0, 2))
					0: begin
						pos = sig_digits(totals.total);
						operand = bcd_operand(pos == 0 ? 0 : $urandom_range(0, pos - 1));
					end
					1: operand = totals.total;
					default: operand = bcd_operand($urandom_range(0, DIGITS));
				endcase
			end else if (sel < 95) begin
				kind = KIND_CMP;
				operand = ($urandom_range(0, 3) == 0) ? totals.total
				                                      : bcd_operand($urandom_range(0, DIGITS));
			end else begin
				kind = KIND_RSVD;
				operand = bcd_operand($urandom_range(0, DIGITS));
			end
			send(kind, operand);
		end
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (totals.errors == 0 && totals.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
